@@ hdl/tmiw_pkg.sv @@
package tmiw_pkg;

  // Packed matrix row: three signed 21-bit entries at bits 0, 21, 42
  localparam int unsigned EntryW = 21;
  localparam int unsigned RowW   = 3 * EntryW;
  localparam int unsigned DispW  = 32;
  localparam int unsigned OutW   = 32;

  // Fraction format of the fractional coordinates
  localparam int unsigned FracS  = 35;

  // Datapath widths
  localparam int unsigned Prod1W = EntryW + DispW;       // inverse entry * Q16.16
  localparam int unsigned SumW   = Prod1W + 2;           // sum of three products
  localparam int unsigned FracW  = FracS + 1;            // signed fraction, [-0.5, 0.5]
  localparam int unsigned Prod2W = EntryW + FracW;       // cell entry * fraction
  localparam int unsigned Sum2W  = Prod2W + 2;           // sum of three products
  localparam int unsigned RoundSh = 31;                  // Q.47 -> Q16.16
  localparam int unsigned RndW   = Sum2W + 1 - RoundSh;  // rounded value width
  localparam int unsigned SatW   = OutW + 1;             // compare width for clamping

  // Register index codes
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    REG_CELL_X = 3'd0,
    REG_CELL_Y = 3'd1,
    REG_CELL_Z = 3'd2,
    REG_INV_X  = 3'd3,
    REG_INV_Y  = 3'd4,
    REG_INV_Z  = 3'd5
  } cfg_reg_e;

  // Reset values: both matrices are the identity
  localparam logic [RowW-1:0] CellXRst = 63'd4096;
  localparam logic [RowW-1:0] CellYRst = 63'd8589934592;
  localparam logic [RowW-1:0] CellZRst = 63'd18014398509481984;
  localparam logic [RowW-1:0] InvXRst  = 63'd524288;
  localparam logic [RowW-1:0] InvYRst  = 63'd1099511627776;
  localparam logic [RowW-1:0] InvZRst  = 63'd2305843009213693952;

  typedef logic [RowW-1:0] row_t;
  typedef logic signed [EntryW-1:0] entry_t;

  // Pick one signed entry out of a packed row
  function automatic entry_t row_entry(input row_t row, input logic [1:0] col);
    entry_t e;
    case (col)
      2'd0:    e = entry_t'(row[0*EntryW +: EntryW]);
      2'd1:    e = entry_t'(row[1*EntryW +: EntryW]);
      default: e = entry_t'(row[2*EntryW +: EntryW]);
    endcase
    return e;
  endfunction

endpackage

@@ hdl/triclinic_minimum_image_wrap_top.sv @@
// Throughput: one vector per cycle while the output is not stalled; four register stages
// (inverse products, sum and fraction, cell products, sum, rounding and clamp) each accept
// a new vector every cycle. Back-pressure stalls only the stages that are full; nothing
// is dropped or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads identity matrices.
module triclinic_minimum_image_wrap_top
  import tmiw_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [RowW-1:0]          cfg_data_i,
  // input vector channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DispW-1:0]  disp_x_i,
  input  logic signed [DispW-1:0]  disp_y_i,
  input  logic signed [DispW-1:0]  disp_z_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [OutW-1:0]   wrapped_x_o,
  output logic signed [OutW-1:0]   wrapped_y_o,
  output logic signed [OutW-1:0]   wrapped_z_o
);

  // Matrix registers
  row_t cell_q [3];
  row_t inv_q  [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q[0] <= CellXRst;
      cell_q[1] <= CellYRst;
      cell_q[2] <= CellZRst;
      inv_q[0]  <= InvXRst;
      inv_q[1]  <= InvYRst;
      inv_q[2]  <= InvZRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CELL_X: cell_q[0] <= cfg_data_i;
        REG_CELL_Y: cell_q[1] <= cfg_data_i;
        REG_CELL_Z: cell_q[2] <= cfg_data_i;
        REG_INV_X:  inv_q[0]  <= cfg_data_i;
        REG_INV_Y:  inv_q[1]  <= cfg_data_i;
        REG_INV_Z:  inv_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valids and advance enables
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en4;

  assign en4 = !vo_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) vo_q <= v3_q;
    end
  end

  // Stage 1: inverse matrix times displacement, one product per entry
  logic signed [DispW-1:0]  disp [3];
  logic signed [Prod1W-1:0] prod1_d [3][3];
  logic signed [Prod1W-1:0] prod1_q [3][3];

  assign disp[0] = disp_x_i;
  assign disp[1] = disp_y_i;
  assign disp[2] = disp_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod1_d[i][j] = Prod1W'(row_entry(inv_q[i], 2'(j))) * Prod1W'(disp[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) prod1_q <= prod1_d;
  end

  // Stage 2: fractional coordinate, minus nearest integer (ties to even)
  logic signed [SumW-1:0]  s_sum [3];
  logic [FracS-1:0]        s_rem [3];
  logic                    s_up  [3];
  logic signed [FracW-1:0] frac_d [3];
  logic signed [FracW-1:0] frac_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_sum[i] = SumW'(prod1_q[i][0]) + SumW'(prod1_q[i][1]) + SumW'(prod1_q[i][2]);
      s_rem[i] = s_sum[i][FracS-1:0];
      // round up when above one half, or exactly half with an odd integer part
      s_up[i]  = (s_rem[i] > {1'b1, {(FracS-1){1'b0}}}) ||
                 ((s_rem[i] == {1'b1, {(FracS-1){1'b0}}}) && s_sum[i][FracS]);
      // rem - 1.0 in two's complement is the remainder with the sign bit set
      frac_d[i] = {s_up[i], s_rem[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) frac_q <= frac_d;
  end

  // Stage 3: cell matrix times fraction vector
  logic signed [Prod2W-1:0] prod2_d [3][3];
  logic signed [Prod2W-1:0] prod2_q [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod2_d[i][j] = Prod2W'(row_entry(cell_q[i], 2'(j))) * Prod2W'(frac_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) prod2_q <= prod2_d;
  end

  // Stage 4: sum, round half up to Q16.16, clamp
  logic signed [Sum2W-1:0] o_sum [3];
  logic signed [Sum2W:0]   o_rnd [3];
  logic signed [RndW-1:0]  o_shr [3];
  logic signed [SatW-1:0]  o_ext [3];
  logic signed [OutW-1:0]  wrap_d [3];
  logic signed [OutW-1:0]  wrap_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_sum[i] = Sum2W'(prod2_q[i][0]) + Sum2W'(prod2_q[i][1]) + Sum2W'(prod2_q[i][2]);
      o_rnd[i] = (Sum2W+1)'(o_sum[i]) + (Sum2W+1)'(64'sd1 <<< (RoundSh - 1));
      o_shr[i] = o_rnd[i][Sum2W:RoundSh];
      o_ext[i] = SatW'(o_shr[i]);
      if (o_ext[i] > SatW'(64'sh7FFF_FFFF)) begin
        wrap_d[i] = {1'b0, {(OutW-1){1'b1}}};
      end else if (o_ext[i] < -SatW'(64'sh8000_0000)) begin
        wrap_d[i] = {1'b1, {(OutW-1){1'b0}}};
      end else begin
        wrap_d[i] = o_ext[i][OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) wrap_q <= wrap_d;
  end

  assign out_valid_o = vo_q;
  assign wrapped_x_o = wrap_q[0];
  assign wrapped_y_o = wrap_q[1];
  assign wrapped_z_o = wrap_q[2];

endmodule

@@ bench/triclinic_minimum_image_wrap_top_tb.sv @@
module triclinic_minimum_image_wrap_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tmiw_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int ItemsPerSet   = 242;
  localparam int NumSettings   = 8;
  localparam int SettleCycles  = 8;
  localparam int HoldCycles    = 64;

  // matrix settings, one per phase
  localparam int SetReset      = 0;
  localparam int SetTriclinic  = 1;
  localparam int SetFullCell   = 2;
  localparam int SetPosMax     = 3;
  localparam int SetNegMax     = 4;
  localparam int SetZero       = 5;
  localparam int SetRandom     = 6;
  localparam int SetIdentity   = 7;
  localparam int HoldSetting   = SetRandom;

  // index codes the block decodes to nothing
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

  localparam int EntryMax = 1048575;
  localparam int EntryMin = -1048576;

  typedef struct packed {
    logic [DispW-1:0] x;
    logic [DispW-1:0] y;
    logic [DispW-1:0] z;
  } vec3_t;

  typedef struct packed {
    vec3_t disp;
    logic  typed;
    vec3_t image;
  } probe_row_t;

  localparam int ProbeN = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [RowW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [DispW-1:0] disp_x_i = '0;
  logic signed [DispW-1:0] disp_y_i = '0;
  logic signed [DispW-1:0] disp_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OutW-1:0] wrapped_x_o;
  logic signed [OutW-1:0] wrapped_y_o;
  logic signed [OutW-1:0] wrapped_z_o;

  // matrix copies seen by the predictor
  row_t cell_rows [3];
  row_t inv_rows [3];

  vec3_t pending_images [$];
  int err_cnt = 0;
  int sent_cnt = 0;
  int recv_cnt = 0;
  int write_cnt = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;

  // identity matrices right after reset; typed rows follow low half / tie parity
  probe_row_t probe_tab [ProbeN] = '{
    '{'{32'h00000000, 32'h00000000, 32'h00000000}, 1'b1,
      '{32'h00000000, 32'h00000000, 32'h00000000}},
    '{'{32'h00008000, 32'h00018000, 32'hFFFF8000}, 1'b1,
      '{32'h00008000, 32'hFFFF8000, 32'hFFFF8000}},
    '{'{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF}, 1'b1,
      '{32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF}},
    '{'{32'h80000000, 32'h7FFFFFFF, 32'h00000000}, 1'b1,
      '{32'h00000000, 32'hFFFFFFFF, 32'h00000000}},
    '{'{32'h00028000, 32'hFFFE8000, 32'h00038000}, 1'b1,
      '{32'h00008000, 32'h00008000, 32'hFFFF8000}},
    '{'{32'h00010000, 32'hFFFF0000, 32'h00007FFF}, 1'b1,
      '{32'h00000000, 32'h00000000, 32'h00007FFF}},
    '{'{32'h00008001, 32'hFFFF7FFF, 32'h7FFF8000}, 1'b1,
      '{32'hFFFF8001, 32'h00007FFF, 32'hFFFF8000}},
    '{'{32'h80008000, 32'h55555555, 32'hAAAAAAAA}, 1'b1,
      '{32'h00008000, 32'h00005555, 32'hFFFFAAAA}},
    '{'{32'h12345678, 32'hDEADBEEF, 32'h0F0F0F0F}, 1'b0, '0},
    '{'{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000}, 1'b0, '0},
    '{'{32'h00C0FFEE, 32'hF00D8000, 32'h3C3C3C3C}, 1'b0, '0},
    '{'{32'h80000001, 32'h7FFF0001, 32'hFFFE0000}, 1'b0, '0}
  };

  triclinic_minimum_image_wrap_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .disp_x_i    (disp_x_i),
    .disp_y_i    (disp_y_i),
    .disp_z_i    (disp_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .wrapped_x_o (wrapped_x_o),
    .wrapped_y_o (wrapped_y_o),
    .wrapped_z_o (wrapped_z_o)
  );

  always #2 clk_i = ~clk_i;

  // signed entry of a packed row, widened
  function automatic longint row_coef(input row_t row, input int col);
    entry_t e;
    e = row[col*EntryW +: EntryW];
    return longint'(e);
  endfunction

  function automatic row_t pack_row(input int c0, input int c1, input int c2);
    return {c2[EntryW-1:0], c1[EntryW-1:0], c0[EntryW-1:0]};
  endfunction

  // fractional coords, drop nearest integer (ties to even), back to Cartesian
  function automatic vec3_t min_image(input vec3_t d_in);
    longint d [3];
    longint f [3];
    longint s, n, rem, o, r;
    longint half;
    logic [DispW-1:0] w [3];
    int i, j;
    half = longint'(1) <<< (FracS - 1);
    d[0] = longint'(signed'(d_in.x));
    d[1] = longint'(signed'(d_in.y));
    d[2] = longint'(signed'(d_in.z));
    for (i = 0; i < 3; i++) begin
      s = 0;
      for (j = 0; j < 3; j++) s += row_coef(inv_rows[i], j) * d[j];
      n = s >>> FracS;
      rem = s - (n <<< FracS);
      if (rem > half || (rem == half && n[0])) n++;
      f[i] = s - (n <<< FracS);
    end
    for (i = 0; i < 3; i++) begin
      o = 0;
      for (j = 0; j < 3; j++) o += row_coef(cell_rows[i], j) * f[j];
      r = (o + (longint'(1) <<< (RoundSh - 1))) >>> RoundSh;
      if (r > longint'(32'sh7FFFFFFF)) r = longint'(32'sh7FFFFFFF);
      if (r < -longint'(64'sh80000000)) r = -longint'(64'sh80000000);
      w[i] = r[DispW-1:0];
    end
    return '{w[0], w[1], w[2]};
  endfunction

  function automatic logic [DispW-1:0] rand_coord();
    logic [DispW-1:0] v;
    logic [31:0] r;
    int unsigned pick;
    pick = $urandom_range(99);
    r = $urandom;
    if (pick < 40) begin
      v = r;
    end else if (pick < 65) begin
      v = $urandom_range(0, 1 << 22);
      if (r[31]) v = -v;
    end else if (pick < 85) begin
      // exact half or whole multiples of the unit length
      v = {r[15:0], (r[16] ? 16'h8000 : 16'h0000)};
    end else begin
      case (r[1:0])
        2'd0:    v = 32'h7FFFFFFF;
        2'd1:    v = 32'h80000000;
        2'd2:    v = 32'h00000000;
        default: v = 32'hFFFFFFFF;
      endcase
    end
    return v;
  endfunction

  function automatic row_t rand_row();
    return row_t'({$urandom, $urandom});
  endfunction

  task automatic report_error(input string msg);
    err_cnt++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // one register write transaction; valid stays high for a following write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input row_t val);
    bit fire;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      fire = cfg_valid_i && cfg_ready_o;
      @(posedge clk_i);
    end while (!fire);
    write_cnt++;
    case (idx)
      REG_CELL_X: cell_rows[0] = val;
      REG_CELL_Y: cell_rows[1] = val;
      REG_CELL_Z: cell_rows[2] = val;
      REG_INV_X:  inv_rows[0] = val;
      REG_INV_Y:  inv_rows[1] = val;
      REG_INV_Z:  inv_rows[2] = val;
      default: ;
    endcase
  endtask

  task automatic load_matrices(input row_t c0, c1, c2, i0, i1, i2);
    write_reg(REG_CELL_X, c0);
    write_reg(REG_CELL_Y, c1);
    write_reg(REG_CELL_Z, c2);
    write_reg(REG_INV_X, i0);
    write_reg(REG_INV_Y, i1);
    write_reg(REG_INV_Z, i2);
  endtask

  // one displacement transaction; each cycle in front of it idles with tx_idle_pct odds
  task automatic offer_disp(input vec3_t d, input bit typed, input vec3_t image);
    bit fire;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    disp_x_i   <= d.x;
    disp_y_i   <= d.y;
    disp_z_i   <= d.z;
    do begin
      @(negedge clk_i);
      fire = in_valid_i && in_ready_o;
      @(posedge clk_i);
    end while (!fire);
    sent_cnt++;
    pending_images.insert(pending_images.size(), typed ? image : min_image(d));
  endtask

  // stop offering and wait out every pending result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_images.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_setting(input int set);
    case (set)
      SetTriclinic: load_matrices(
        pack_row(40960, 8192, 4096), pack_row(0, 36864, 6144), pack_row(0, 0, 32768),
        pack_row(52429, -11651, -4369), pack_row(0, 58254, -10923), pack_row(0, 0, 65536));
      // same cell replicated three times along each edge
      SetFullCell: load_matrices(
        pack_row(122880, 24576, 12288), pack_row(0, 110592, 18432), pack_row(0, 0, 98304),
        pack_row(17476, -3884, -1456), pack_row(0, 19418, -3641), pack_row(0, 0, 21845));
      SetPosMax: load_matrices(
        pack_row(EntryMax, EntryMax, EntryMax), pack_row(EntryMax, EntryMax, EntryMax),
        pack_row(EntryMax, EntryMax, EntryMax), pack_row(EntryMin, EntryMin, EntryMin),
        pack_row(EntryMin, EntryMin, EntryMin), pack_row(EntryMin, EntryMin, EntryMin));
      SetNegMax: load_matrices(
        pack_row(EntryMin, EntryMin, EntryMin), pack_row(EntryMin, EntryMin, EntryMin),
        pack_row(EntryMin, EntryMin, EntryMin), pack_row(EntryMax, EntryMax, EntryMax),
        pack_row(EntryMax, EntryMax, EntryMax), pack_row(EntryMax, EntryMax, EntryMax));
      SetZero: begin
        load_matrices('0, '0, '0, '0, '0, '0);
        // spare indexes must leave the matrices alone
        write_reg(RegSpare6, rand_row());
        write_reg(RegSpare7, rand_row());
      end
      SetRandom: load_matrices(rand_row(), rand_row(), rand_row(),
                               rand_row(), rand_row(), rand_row());
      SetIdentity: load_matrices(CellXRst, CellYRst, CellZRst, InvXRst, InvYRst, InvZRst);
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver: random back-pressure plus one long hold on request
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result check; handshake seen mid-cycle, transaction at the next edge
  always @(negedge clk_i) begin
    vec3_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      recv_cnt++;
      if (pending_images.size() == 0) begin
        report_error($sformatf("unexpected result %h %h %h",
                               wrapped_x_o, wrapped_y_o, wrapped_z_o));
      end else begin
        want = pending_images.pop_front();
        if (wrapped_x_o !== want.x)
          report_error($sformatf("result %0d x: got %h want %h", recv_cnt, wrapped_x_o, want.x));
        if (wrapped_y_o !== want.y)
          report_error($sformatf("result %0d y: got %h want %h", recv_cnt, wrapped_y_o, want.y));
        if (wrapped_z_o !== want.z)
          report_error($sformatf("result %0d z: got %h want %h", recv_cnt, wrapped_z_o, want.z));
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("watchdog expired after %0d cycles, %0d results pending",
             cycle_cnt, pending_images.size());
    $display("TEST FAILED");
    $finish;
  end

  // stimulus
  initial begin
    cell_rows = '{CellXRst, CellYRst, CellZRst};
    inv_rows  = '{InvXRst, InvYRst, InvZRst};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 32;
    rx_idle_pct = 63;
    foreach (probe_tab[k])
      offer_disp(probe_tab[k].disp, probe_tab[k].typed, probe_tab[k].image);

    for (int set = 0; set < NumSettings; set++) begin
      if (set != SetReset) begin
        settle();
        apply_setting(set);
      end
      if (set < SetPosMax) begin
        tx_idle_pct = 32;
        rx_idle_pct = 63;
      end else if (set < SetRandom) begin
        tx_idle_pct = 63;
        rx_idle_pct = 32;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (set == HoldSetting) hold_req = 1'b1;
      for (int k = 0; k < ItemsPerSet; k++)
        offer_disp(vec3_t'{rand_coord(), rand_coord(), rand_coord()}, 1'b0, '0);
    end

    settle();
    $display("Checked %0d wrapped vectors over %0d matrix settings (%0d register writes).",
             recv_cnt, NumSettings, write_cnt);
    $display("Covered ties to even, range extremes, extreme entries and output stalls.");
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
